// File: src/radix_conversion_assert.svh
// Assertion macros used by the radix conversion checker.
`ifndef RADIX_CONVERSION_ASSERT_SVH
`define RADIX_CONVERSION_ASSERT_SVH

// Property checked at every rising clock edge outside reset.
`define RC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define RC_ASSERT_NEXT(lbl, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) else $error(msg);

`endif

// File: src/rc_pkg.sv
// Types, constants and helper functions of the radix conversion block.
`default_nettype none
package rc_pkg;

	localparam int DEF_VALUE_BITS = 32;
	localparam int DEF_OUT_DIGITS = 32;
	localparam int QUEUE_DEPTH    = 2;
	localparam int DIV_BITS       = 4;
	localparam int BASE_BITS      = 6;

	localparam logic [BASE_BITS-1:0] BASE_MIN      = 6'd2;
	localparam logic [BASE_BITS-1:0] BASE_MAX      = 6'd36;
	localparam logic [BASE_BITS-1:0] RESET_IN_BASE  = 6'd10;
	localparam logic [BASE_BITS-1:0] RESET_OUT_BASE = 6'd2;
	localparam logic [BASE_BITS-1:0] DEC_DIGITS     = 6'd10;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;

	typedef enum logic [0:0] {
		REG_IN_BASE  = 1'b0,
		REG_OUT_BASE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] digit_char;
		logic       digit_last;
	} digit_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_last;
		logic       overflow;
		logic       bad_digit;
	} result_t;

	typedef struct packed {
		logic overflow;
		logic bad;
	} rc_flags_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_READ,
		B_LOAD
	} back_state_t;

	function automatic logic [BASE_BITS-1:0] clamp_base(logic [BASE_BITS-1:0] b);
		logic [BASE_BITS-1:0] r;
		r = b;
		if (b < BASE_MIN)
			r = BASE_MIN;
		else if (b > BASE_MAX)
			r = BASE_MAX;
		return r;
	endfunction

	// {bad, value}; bad characters read as zero
	function automatic logic [BASE_BITS:0] char_value(logic [7:0] c,
			logic [BASE_BITS-1:0] base);
		logic [7:0] v;
		logic       bad;
		bad = 1'b0;
		v   = '0;
		if (c >= CH_UP_A && c <= CH_UP_Z)
			v = c - CH_UP_A + 8'(DEC_DIGITS);
		else if (c >= CH_LO_A && c <= CH_LO_Z)
			v = c - CH_LO_A + 8'(DEC_DIGITS);
		else if (c >= CH_0 && c <= CH_9)
			v = c - CH_0;
		else
			bad = 1'b1;
		if (!bad && v >= 8'(base))
			bad = 1'b1;
		if (bad)
			v = '0;
		return {bad, v[BASE_BITS-1:0]};
	endfunction

	function automatic logic [7:0] digit_to_char(logic [BASE_BITS-1:0] d);
		logic [7:0] c;
		if (d < DEC_DIGITS)
			c = CH_0 + 8'(d);
		else
			c = CH_UP_A + 8'(d - DEC_DIGITS);
		return c;
	endfunction

endpackage
`default_nettype wire

// File: src/rc_front.sv
// Front end: decodes digit characters and folds them into the value by Horner's rule.
`default_nettype none
module rc_front import rc_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [BASE_BITS-1:0]    in_base,
	input  wire logic                    digit_valid,
	output logic                         digit_ready,
	input  wire digit_t                  digit,
	input  wire logic                    q_ready,
	output logic                         q_push,
	output logic [VALUE_BITS+1:0]        q_data
);

	localparam int SW = VALUE_BITS + BASE_BITS + 1;

	logic [VALUE_BITS-1:0] acc_q;
	rc_flags_t             flags_q;
	logic [BASE_BITS-1:0]  ib;
	logic [BASE_BITS:0]    cv;
	logic [SW-1:0]         sum;
	logic                  wrap;
	rc_flags_t             flags_n;
	logic                  take;

	always_comb begin
		ib   = clamp_base(in_base);
		cv   = char_value(digit.digit_char, ib);
		sum  = SW'(acc_q) * SW'(ib) + SW'(cv[BASE_BITS-1:0]);
		wrap = |sum[SW-1:VALUE_BITS];
		flags_n.overflow = flags_q.overflow | wrap;
		flags_n.bad      = flags_q.bad | cv[BASE_BITS];
	end

	// a digit is taken only while the queue has room, whether it closes a number or not
	assign digit_ready = q_ready;
	assign take        = digit_valid & digit_ready;
	assign q_push      = take & digit.digit_last;
	assign q_data      = {sum[VALUE_BITS-1:0], flags_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			flags_q <= '0;
		end else if (take) begin
			if (digit.digit_last) begin
				acc_q   <= '0;
				flags_q <= '0;
			end else begin
				acc_q   <= sum[VALUE_BITS-1:0];
				flags_q <= flags_n;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/rc_queue.sv
// Short queue of finished values between front and back.
`default_nettype none
module rc_queue import rc_pkg::*; #(
	parameter int W     = DEF_VALUE_BITS + 2,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              ready,
	input  wire logic         pop,
	output logic              valid,
	output logic [W-1:0]      pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign ready    = cnt_q != CW'(DEPTH);
	assign valid    = cnt_q != '0;
	assign pop_data = slot_q[rd_ptr_q];
	assign do_push  = push & ready;
	assign do_pop   = pop & valid;

	function automatic logic [PW-1:0] bump(logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= bump(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= bump(rd_ptr_q);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

// File: src/rc_back.sv
// Back end: repeated division by the output radix, digit store and character read-out.
`default_nettype none
module rc_back import rc_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS,
	parameter int OUT_DIGITS = DEF_OUT_DIGITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [BASE_BITS-1:0] out_base,
	input  wire logic                 q_valid,
	input  wire logic [VALUE_BITS+1:0] q_data,
	output logic                      q_pop,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output result_t                   result
);

	localparam int DS    = DIV_BITS;
	localparam int STEPS = (VALUE_BITS + DS - 1) / DS;
	localparam int PADW  = STEPS * DS;
	localparam int SW    = $clog2(STEPS);
	localparam int AW    = $clog2(OUT_DIGITS);
	localparam int CW    = $clog2(OUT_DIGITS + 1);

	back_state_t          state_q, state_d;
	logic [PADW-1:0]      work_q, work_n;
	logic [BASE_BITS-1:0] rem_q, rem_n;
	logic [SW-1:0]        step_q;
	logic [CW-1:0]        count_q, cnt_inc;
	logic [AW-1:0]        idx_q;
	rc_flags_t            flags_q;
	logic [BASE_BITS-1:0] store_q [OUT_DIGITS];
	logic [BASE_BITS-1:0] rd_q;
	result_t              res_q;
	logic                 res_valid_q;
	logic [BASE_BITS-1:0] ob;
	logic [DS-1:0]        qbits;
	logic                 last_step;
	logic                 quot_nz;
	logic                 cut;
	logic                 wr_en;
	logic                 load;

	// DS long-division bits per cycle, value walked MSB first
	always_comb begin
		logic [BASE_BITS:0] t;
		ob    = clamp_base(out_base);
		rem_n = rem_q;
		qbits = '0;
		for (int i = 0; i < DS; i++) begin
			t = {rem_n, work_q[PADW-1-i]};
			if (t >= {1'b0, ob}) begin
				t = t - {1'b0, ob};
				qbits[DS-1-i] = 1'b1;
			end
			rem_n = t[BASE_BITS-1:0];
		end
		work_n = {work_q[PADW-DS-1:0], qbits};
	end

	assign last_step = step_q == SW'(STEPS - 1);
	assign quot_nz   = |work_n;
	assign cnt_inc   = count_q + 1'b1;
	assign cut       = quot_nz && (cnt_inc == CW'(OUT_DIGITS));

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		wr_en   = 1'b0;
		load    = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = B_DIV;
				end
			end
			B_DIV: begin
				if (last_step) begin
					wr_en = 1'b1;
					if (!quot_nz || cut)
						state_d = B_READ;
				end
			end
			B_READ: begin
				if (!res_valid_q || result_ready)
					state_d = B_LOAD;
			end
			B_LOAD: begin
				load    = 1'b1;
				state_d = (idx_q == '0) ? B_IDLE : B_READ;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			step_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				step_q  <= '0;
				count_q <= '0;
			end else if (state_q == B_DIV) begin
				step_q <= last_step ? '0 : step_q + 1'b1;
				if (last_step) begin
					count_q <= cnt_inc;
					idx_q   <= AW'(cnt_inc - 1'b1);
				end
			end else if (load && idx_q != '0) begin
				idx_q <= idx_q - 1'b1;
			end
			if (load)
				res_valid_q <= 1'b1;
			else if (result_ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			work_q  <= PADW'(q_data[VALUE_BITS+1:2]);
			flags_q <= rc_flags_t'(q_data[1:0]);
			rem_q   <= '0;
		end else if (state_q == B_DIV) begin
			work_q <= work_n;
			rem_q  <= last_step ? '0 : rem_n;
			if (last_step && cut)
				flags_q.overflow <= 1'b1;
		end
		if (load) begin
			res_q.out_char  <= digit_to_char(rd_q);
			res_q.out_last  <= idx_q == '0;
			res_q.overflow  <= flags_q.overflow;
			res_q.bad_digit <= flags_q.bad;
		end
	end

	// digit store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			store_q[count_q[AW-1:0]] <= rem_n;
		rd_q <= store_q[idx_q];
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule
`default_nettype wire

// File: src/radix_conversion.sv
// Top level of the radix conversion block: configuration registers and the front/back split.
//
// Usage
//   cfg channel: write in_base (index REG_IN_BASE) or out_base (REG_OUT_BASE), only
//   while the block is idle. cfg_ready is always high. Values outside 2..36 clamp.
//   digit channel: one ASCII digit per transfer, most significant first; digit_last
//   closes the number. Letters of either case are 10..35; anything else, or a digit
//   not below in_base, reads as zero and raises bad_digit.
//   result channel: the value in out_base as ASCII, most significant first, out_last
//   on the final character. overflow flags a wrapped value or a cut digit string.
// Timing
//   The front takes one digit per cycle while the queue has room (one multiply-add into
//   the accumulator). Finished values wait in a two-entry queue. The back divides by
//   out_base in its 4-bit-per-cycle divider, one output digit per pass over the value,
//   then reads each character from the digit store through B_READ and B_LOAD.
//   It takes the next value from the queue only after the last character is loaded.
// Reset: arst_n clears the accumulator, queue and back end; bases return to 10 and 2.
// Stall: a held result keeps the back waiting; the front keeps taking digits until
//   the queue is full, then drops digit_ready.
`default_nettype none
module radix_conversion import rc_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS,
	parameter int OUT_DIGITS = DEF_OUT_DIGITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire cfg_reg_t             cfg_index,
	input  wire logic [BASE_BITS-1:0] cfg_data,
	input  wire logic                 digit_valid,
	output logic                      digit_ready,
	input  wire digit_t               digit,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output result_t                   result
);

	localparam int QW = VALUE_BITS + $bits(rc_flags_t);

	logic [BASE_BITS-1:0] in_base_q;
	logic [BASE_BITS-1:0] out_base_q;
	logic                 q_push;
	logic [QW-1:0]        q_wdata;
	logic                 q_ready;
	logic                 q_pop;
	logic                 q_valid;
	logic [QW-1:0]        q_rdata;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_base_q  <= RESET_IN_BASE;
			out_base_q <= RESET_OUT_BASE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IN_BASE:  in_base_q  <= cfg_data;
				REG_OUT_BASE: out_base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: Horner accumulation, one digit per cycle while the queue has room
	rc_front #(
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_base     (in_base_q),
		.digit_valid (digit_valid),
		.digit_ready (digit_ready),
		.digit       (digit),
		.q_ready     (q_ready),
		.q_push      (q_push),
		.q_data      (q_wdata)
	);

	// decouples the two halves so a stalled receiver does not stop digit intake until the queue is full
	rc_queue #(
		.W     (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.ready     (q_ready),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_rdata)
	);

	// back: division loop and character read-out
	rc_back #(
		.VALUE_BITS (VALUE_BITS),
		.OUT_DIGITS (OUT_DIGITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.out_base     (out_base_q),
		.q_valid      (q_valid),
		.q_data       (q_rdata),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
`default_nettype wire

// File: src/rc_checker.sv
// Port-level checker for the radix conversion block, bound to the top level.
`default_nettype none
`include "radix_conversion_assert.svh"
module rc_checker import rc_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 cfg_valid,
	input wire logic                 cfg_ready,
	input wire logic                 digit_valid,
	input wire logic                 digit_ready,
	input wire digit_t               digit,
	input wire logic                 result_valid,
	input wire logic                 result_ready,
	input wire result_t              result
);

	logic [3:0] pend_q;
	logic       num_in;
	logic       num_out;

	assign num_in   = digit_valid & digit_ready & digit.digit_last;
	assign num_out  = result_valid & result_ready & result.out_last;

	// numbers closed on the digit side but not yet finished on the result side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else if (num_in && !num_out)
			pend_q <= pend_q + 1'b1;
		else if (num_out && !num_in)
			pend_q <= pend_q - 1'b1;
	end

	`RC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
		result_valid && $stable(result), "result changed while stalled")
	`RC_ASSERT(a_legal_char, !result_valid || (result.out_char >= CH_0 && result.out_char <= CH_9)
		|| (result.out_char >= CH_UP_A && result.out_char <= CH_UP_Z),
		"result character is not a base-36 digit")
	`RC_ASSERT(a_cfg_idle, !(cfg_valid && cfg_ready) || (pend_q == '0 && !digit_valid),
		"configuration written with a number in flight")
	`RC_ASSERT(a_pending, !result_valid || pend_q != '0, "result without a closed number")

endmodule

bind radix_conversion rc_checker u_rc_checker (.*);
`default_nettype wire

// File: tb/radix_conversion_tb.sv
// Self-checking testbench for the radix conversion block: digit strings in, converted characters out.
`timescale 1ns / 1ps
module radix_conversion_tb;
	import rc_pkg::*;

	localparam int VALUE_BITS    = DEF_VALUE_BITS;
	localparam int OUT_DIGITS    = DEF_OUT_DIGITS;
	localparam int SETTLE_CYCLES = 300;     // covers the back-end latency with margin
	localparam int HOLD_CYCLES   = 400;     // long result stall to fill the value queue
	localparam int TIMEOUT_NS    = 2000000;
	localparam int PHASE_DIGITS  = 28;      // minimum random digits per configuration phase

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// DUT ports; every input has a known value from time zero
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	cfg_reg_t             cfg_index    = REG_IN_BASE;
	logic [BASE_BITS-1:0] cfg_data     = '0;
	logic                 digit_valid  = 1'b0;
	logic                 digit_ready;
	digit_t               digit        = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	result_t              result;

	// stimulus bookkeeping
	digit_t      pending_digits[$];
	int unsigned digits_queued = 0;
	int unsigned digits_taken  = 0;
	logic        digit_took    = 1'b0;     // transfer seen at the last rising edge

	// idling controls, changed between phases only
	int unsigned send_gap_pct = 26;
	int unsigned stall_pct    = 50;
	int unsigned hold_asked   = 0;
	int unsigned hold_served  = 0;
	int unsigned hold_left    = 0;

	// predictor state: mirrors the block's registers and accumulator
	logic [BASE_BITS-1:0]  model_in_base  = RESET_IN_BASE;
	logic [BASE_BITS-1:0]  model_out_base = RESET_OUT_BASE;
	logic [VALUE_BITS-1:0] acc_value      = '0;
	logic                  wrap_seen      = 1'b0;
	logic                  bad_char_seen  = 1'b0;
	result_t               expected_chars[$];

	int unsigned error_count = 0;

	radix_conversion i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.digit_valid (digit_valid),
		.digit_ready (digit_ready),
		.digit       (digit),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Register values outside 2..36 behave as the nearest bound.
	function automatic logic [BASE_BITS-1:0] eff_base(logic [BASE_BITS-1:0] raw);
		if (raw < BASE_MIN)
			return BASE_MIN;
		if (raw > BASE_MAX)
			return BASE_MAX;
		return raw;
	endfunction

	// Fold one accepted digit into the accumulator (Horner); on the last digit
	// convert to out_base and queue the characters, most significant first.
	task automatic fold_digit(input digit_t d);
		logic [BASE_BITS-1:0]  ib;
		logic [BASE_BITS-1:0]  ob;
		logic [7:0]            c;
		logic [7:0]            dv;
		logic [VALUE_BITS+7:0] prod;
		logic [VALUE_BITS-1:0] rest;
		logic [BASE_BITS-1:0]  conv_digits[$];
		logic [BASE_BITS-1:0]  dg;
		int                    k;
		ib = eff_base(model_in_base);
		ob = eff_base(model_out_base);
		c  = d.digit_char;
		if (c >= CH_UP_A && c <= CH_UP_Z)
			dv = c - CH_UP_A + 8'd10;
		else if (c >= CH_LO_A && c <= CH_LO_Z)
			dv = c - CH_LO_A + 8'd10;
		else if (c >= CH_0 && c <= CH_9)
			dv = c - CH_0;
		else begin
			dv = 8'hFF;         // forces the invalid path below
		end
		// non-digits and digits not below the base read as zero
		if (dv >= 8'(ib)) begin
			dv = '0;
			bad_char_seen = 1'b1;
		end
		prod = (VALUE_BITS+8)'(acc_value) * ib + dv;
		if ((prod >> VALUE_BITS) != 0)
			wrap_seen = 1'b1;
		acc_value = prod[VALUE_BITS-1:0];
		if (!d.digit_last)
			return;
		// low digit first; a string longer than OUT_DIGITS is cut
		rest = acc_value;
		do begin
			if (conv_digits.size() >= OUT_DIGITS) begin
				wrap_seen = 1'b1;
				break;
			end
			conv_digits.push_back(BASE_BITS'(rest % ob));
			rest = rest / ob;
		end while (rest != 0);
		for (k = conv_digits.size() - 1; k >= 0; k--) begin
			dg = conv_digits[k];
			expected_chars.push_back(result_t'{
				out_char:  (dg < 10) ? CH_0 + 8'(dg) : CH_UP_A + 8'(dg - 10),
				out_last:  (k == 0),
				overflow:  wrap_seen,
				bad_digit: bad_char_seen});
		end
		acc_value     = '0;
		wrap_seen     = 1'b0;
		bad_char_seen = 1'b0;
	endtask

	// Monitor: everything is sampled at the rising edge, inputs having settled at the falling one.
	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			digit_took     = 1'b0;
			model_in_base  = RESET_IN_BASE;
			model_out_base = RESET_OUT_BASE;
			acc_value      = '0;
			wrap_seen      = 1'b0;
			bad_char_seen  = 1'b0;
		end else begin
			digit_took = digit_valid && digit_ready;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_IN_BASE:  model_in_base  = cfg_data;
					REG_OUT_BASE: model_out_base = cfg_data;
				endcase
			end
			if (digit_took) begin
				fold_digit(digit);
				digits_taken++;
			end
			if (result_valid && result_ready) begin
				if (expected_chars.size() == 0) begin
					$error("result transfer with nothing expected: char %h last %b",
						result.out_char, result.out_last);
					error_count++;
				end else begin
					want = expected_chars.pop_front();
					if (result.out_char !== want.out_char) begin
						$error("out_char: expected %h, got %h", want.out_char, result.out_char);
						error_count++;
					end
					if (result.out_last !== want.out_last) begin
						$error("out_last: expected %b, got %b", want.out_last, result.out_last);
						error_count++;
					end
					if (result.overflow !== want.overflow) begin
						$error("overflow: expected %b, got %b", want.overflow, result.overflow);
						error_count++;
					end
					if (result.bad_digit !== want.bad_digit) begin
						$error("bad_digit: expected %b, got %b", want.bad_digit, result.bad_digit);
						error_count++;
					end
				end
			end
		end
	end

	// Digit driver: a new item (or a gap) only once the current one has gone.
	always @(negedge clk) begin
		if (!arst_n) begin
			digit_valid <= 1'b0;
		end else if (!digit_valid || digit_took) begin
			if (pending_digits.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				digit       <= pending_digits.pop_front();
				digit_valid <= 1'b1;
			end else begin
				digit_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, plus a long hold-off when one is asked for.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else if (hold_served != hold_asked) begin
			hold_served  = hold_asked;
			hold_left    = HOLD_CYCLES;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic queue_char(input logic [7:0] c, input logic last);
		pending_digits.push_back(digit_t'{digit_char: c, digit_last: last});
		digits_queued++;
	endtask

	task automatic queue_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			queue_char(s[i], i == s.len() - 1);
	endtask

	// Block is idle once every digit has gone in and every character come out;
	// then give the back end time to finish any clearing.
	task automatic wait_idle;
		do
			@(negedge clk);
		while (digits_taken != digits_queued || expected_chars.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [BASE_BITS-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed numbers with random content; one char in ten is noise.
	// Now and then a long string, enough to wrap the accumulator in small bases.
	task automatic queue_random_number(input logic [BASE_BITS-1:0] ib,
			output int unsigned len);
		int unsigned k;
		int unsigned v;
		logic [7:0]  c;
		len = ($urandom_range(7) == 0) ? $urandom_range(1, 34) : $urandom_range(1, 6);
		for (k = 0; k < len; k++) begin
			if ($urandom_range(9) == 0) begin
				c = 8'($urandom_range(255));
			end else begin
				v = $urandom_range(ib - 1);
				if (v < 10)
					c = CH_0 + 8'(v);
				else if ($urandom_range(1))
					c = CH_UP_A + 8'(v - 10);
				else
					c = CH_LO_A + 8'(v - 10);
			end
			queue_char(c, k == len - 1);
		end
	endtask

	task automatic run_phase(input logic [BASE_BITS-1:0] in_raw,
			input logic [BASE_BITS-1:0] out_raw, input logic long_hold);
		int unsigned n;
		int unsigned len;
		wait_idle();
		write_reg(REG_IN_BASE, in_raw);
		write_reg(REG_OUT_BASE, out_raw);
		if (long_hold)
			hold_asked++;
		n = 0;
		while (n < PHASE_DIGITS) begin
			queue_random_number(eff_base(in_raw), len);
			n += len;
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset bases 10 -> 2
		queue_text("0");                     // zero gives a single '0'
		queue_text("4294967295");            // all ones, longest binary string
		queue_text("A");                     // letter not below base ten
		queue_char(8'hFF, 1'b0);             // non-digit extremes of the field
		queue_char(8'h00, 1'b1);

		// directed, base 36 both ways: letters of both cases, then a wrap
		wait_idle();
		write_reg(REG_IN_BASE, BASE_MAX);
		write_reg(REG_OUT_BASE, BASE_MAX);
		queue_text("Za");
		queue_text("zZzZzZz");

		// random, sender 26 / receiver 50
		run_phase(6'd2, 6'd36, 1'b0);
		run_phase(6'd36, 6'd2, 1'b0);

		// random, sender 50 / receiver 26; bases out of range clamp
		wait_idle();
		send_gap_pct = 50;
		stall_pct    = 26;
		run_phase(6'd0, 6'd63, 1'b0);
		run_phase(6'd63, 6'd1, 1'b1);       // long result stall fills the queue

		// random, no idling
		wait_idle();
		send_gap_pct = 0;
		stall_pct    = 0;
		run_phase(6'($urandom_range(2, 36)), 6'($urandom_range(2, 36)), 1'b0);
		run_phase(6'($urandom_range(63)), 6'($urandom_range(63)), 1'b0);
		run_phase(6'd37, 6'd10, 1'b0);

		wait_idle();
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("simulation failed");
		$finish;
	end

endmodule

// File: files.f
+incdir+src
src/rc_pkg.sv
src/rc_front.sv
src/rc_queue.sv
src/rc_back.sv
src/radix_conversion.sv
src/rc_checker.sv
tb/radix_conversion_tb.sv
